// ===== src/lsc_pkg.sv =====
// Package: shared types and constants for the line segment window clipper.
`default_nettype none
package lsc_pkg;

	localparam int COORD_WIDTH = 16;
	// Differences of two coordinates and fraction terms
	localparam int WIDE_WIDTH = COORD_WIDTH + 1;
	// Cross products of two wide terms
	localparam int PROD_WIDTH = 2 * WIDE_WIDTH;
	localparam int NUM_BOUNDS = 4;
	localparam int NUM_LANES = 4;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [WIDE_WIDTH-1:0] wide_t;
	typedef logic signed [PROD_WIDTH-1:0] prod_t;
	typedef logic [COORD_WIDTH-1:0] mag_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_WIN_X_MIN = 2'd0,
		REG_WIN_Y_MIN = 2'd1,
		REG_WIN_X_MAX = 2'd2,
		REG_WIN_Y_MAX = 2'd3
	} reg_idx_t;

	localparam coord_t WIN_X_MIN_RST = COORD_WIDTH'(0);
	localparam coord_t WIN_Y_MIN_RST = COORD_WIDTH'(0);
	localparam coord_t WIN_X_MAX_RST = COORD_WIDTH'(639);
	localparam coord_t WIN_Y_MAX_RST = COORD_WIDTH'(479);

	typedef struct packed {
		coord_t start_x;
		coord_t start_y;
		coord_t end_x;
		coord_t end_y;
	} seg_t;

	typedef struct packed {
		logic   visible;
		coord_t clip_start_x;
		coord_t clip_start_y;
		coord_t clip_end_x;
		coord_t clip_end_y;
	} clip_t;

	// Which boundary a cell tests
	typedef struct packed {
		logic lo_side;
		logic y_axis;
	} bsel_t;

	// Segment and parameter interval [n0/d0, n1/d1] carried down the boundary cells
	typedef struct packed {
		coord_t x0;
		coord_t y0;
		wide_t  dx;
		wide_t  dy;
		wide_t  n0;
		wide_t  d0;
		wide_t  n1;
		wide_t  d1;
		logic   ok;
	} tstate_t;

	// Products formed in the first half of a boundary cell
	typedef struct packed {
		tstate_t st;
		wide_t   tn;
		wide_t   td;
		logic    pz;
		logic    pneg;
		logic    qneg;
		prod_t   tn_d0;
		prod_t   n0_td;
		prod_t   tn_d1;
		prod_t   n1_td;
	} bmul_t;

	// One coordinate under restoring division
	typedef struct packed {
		coord_t x;
		logic   neg;
		mag_t   d;
		mag_t   rem;
		mag_t   dvd;
		mag_t   quo;
	} lane_t;

	typedef struct packed {
		logic                  ok;
		lane_t [NUM_LANES-1:0] lane;
	} divst_t;

endpackage
`default_nettype wire

// ===== src/lsc_bound_cell.sv =====
// Boundary cell: cross-multiplies and narrows the parameter interval for one window edge.
`default_nettype none
module lsc_bound_cell (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             adv,
	input  wire lsc_pkg::bsel_t   sel,
	input  wire lsc_pkg::coord_t  win,
	input  wire logic             in_vld,
	input  wire lsc_pkg::tstate_t in_st,
	output logic                  out_vld,
	output lsc_pkg::tstate_t      out_st
);

	logic            vld_s1;
	lsc_pkg::bmul_t  mul_s1;
	lsc_pkg::bmul_t  mul_d;
	lsc_pkg::tstate_t nxt_st;
	lsc_pkg::wide_t  pos;
	lsc_pkg::wide_t  delta;
	lsc_pkg::wide_t  p;
	lsc_pkg::wide_t  q;

	// Form p and q for this edge, then the four cross products
	always_comb begin
		pos   = sel.y_axis ? lsc_pkg::WIDE_WIDTH'(in_st.y0) : lsc_pkg::WIDE_WIDTH'(in_st.x0);
		delta = sel.y_axis ? in_st.dy : in_st.dx;
		if (sel.lo_side) begin
			p = -delta;
			q = pos - lsc_pkg::WIDE_WIDTH'(win);
		end else begin
			p = delta;
			q = lsc_pkg::WIDE_WIDTH'(win) - pos;
		end
		mul_d.st    = in_st;
		mul_d.pz    = (p == '0);
		mul_d.pneg  = p[lsc_pkg::WIDE_WIDTH-1];
		mul_d.qneg  = q[lsc_pkg::WIDE_WIDTH-1];
		mul_d.tn    = mul_d.pneg ? -q : q;
		mul_d.td    = mul_d.pneg ? -p : p;
		mul_d.tn_d0 = mul_d.tn * in_st.d0;
		mul_d.n0_td = in_st.n0 * mul_d.td;
		mul_d.tn_d1 = mul_d.tn * in_st.d1;
		mul_d.n1_td = in_st.n1 * mul_d.td;
	end

	// Reject or tighten the interval from the registered products
	always_comb begin
		nxt_st = mul_s1.st;
		if (mul_s1.st.ok) begin
			priority if (mul_s1.pz) begin
				if (mul_s1.qneg) nxt_st.ok = 1'b0;
			end else if (mul_s1.pneg) begin
				if (mul_s1.tn_d1 > mul_s1.n1_td) begin
					nxt_st.ok = 1'b0;
				end else if (mul_s1.tn_d0 > mul_s1.n0_td) begin
					nxt_st.n0 = mul_s1.tn;
					nxt_st.d0 = mul_s1.td;
				end
			end else begin
				if (mul_s1.tn_d0 < mul_s1.n0_td) begin
					nxt_st.ok = 1'b0;
				end else if (mul_s1.tn_d1 < mul_s1.n1_td) begin
					nxt_st.n1 = mul_s1.tn;
					nxt_st.d1 = mul_s1.td;
				end
			end
		end
	end

	// Advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			out_vld <= 1'b0;
		end else if (adv) begin
			vld_s1  <= in_vld;
			out_vld <= vld_s1;
		end
	end

	// Advance the payload
	always_ff @(posedge clk) begin
		if (adv) begin
			mul_s1 <= mul_d;
			out_st <= nxt_st;
		end
	end

endmodule
`default_nettype wire

// ===== src/lsc_div_cell.sv =====
// Division cell: one restoring step for each of the four clipped coordinates.
`default_nettype none
module lsc_div_cell (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            adv,
	input  wire logic            in_vld,
	input  wire lsc_pkg::divst_t in_dv,
	output logic                 out_vld,
	output lsc_pkg::divst_t      out_dv
);

	lsc_pkg::divst_t nxt_dv;

	// Shift in one dividend bit and subtract the divisor where it fits
	always_comb begin
		logic [lsc_pkg::COORD_WIDTH:0] r2;
		logic [lsc_pkg::COORD_WIDTH:0] diff;
		logic                          ge;
		nxt_dv = in_dv;
		for (int j = 0; j < lsc_pkg::NUM_LANES; j++) begin
			r2   = {in_dv.lane[j].rem, in_dv.lane[j].dvd[lsc_pkg::COORD_WIDTH-1]};
			diff = r2 - {1'b0, in_dv.lane[j].d};
			ge   = (r2 >= {1'b0, in_dv.lane[j].d});
			nxt_dv.lane[j].rem = ge ? diff[lsc_pkg::COORD_WIDTH-1:0]
			                        : r2[lsc_pkg::COORD_WIDTH-1:0];
			nxt_dv.lane[j].dvd = {in_dv.lane[j].dvd[lsc_pkg::COORD_WIDTH-2:0], 1'b0};
			nxt_dv.lane[j].quo = {in_dv.lane[j].quo[lsc_pkg::COORD_WIDTH-2:0], ge};
		end
	end

	// Advance the valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (adv) begin
			out_vld <= in_vld;
		end
	end

	// Advance the payload
	always_ff @(posedge clk) begin
		if (adv) begin
			out_dv <= nxt_dv;
		end
	end

endmodule
`default_nettype wire

// ===== src/line_segment_window_clip.sv =====
// Top level: Liang-Barsky segment clipper against a programmable window.
// Throughput: one item per cycle when no result waits with clip_stall high; input register,
// four two-stage boundary cells, one product stage, COORD_WIDTH division cells and the output
// register form the pipeline.
// The whole pipeline holds while a result waits with clip_stall high.
// Reset clears all valid bits and loads the window to (0,0)-(639,479).
`default_nettype none
module line_segment_window_clip (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              seg_valid,
	output logic                   seg_stall,
	input  wire lsc_pkg::seg_t     seg,
	output logic                   clip_valid,
	input  wire logic              clip_stall,
	output lsc_pkg::clip_t         clip,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire lsc_pkg::reg_idx_t cfg_index,
	input  wire lsc_pkg::coord_t   cfg_data
);

	localparam int CW = lsc_pkg::COORD_WIDTH;
	localparam int NB = lsc_pkg::NUM_BOUNDS;

	logic             adv;
	lsc_pkg::coord_t  win_x_min_q;
	lsc_pkg::coord_t  win_y_min_q;
	lsc_pkg::coord_t  win_x_max_q;
	lsc_pkg::coord_t  win_y_max_q;
	lsc_pkg::coord_t  bwin [NB];
	logic             stv [NB+1];
	lsc_pkg::tstate_t st [NB+1];
	logic             dvv [CW+1];
	lsc_pkg::divst_t  dv [CW+1];
	lsc_pkg::divst_t  dv_d;
	lsc_pkg::clip_t   clip_d;

	// Move the whole pipeline unless a finished item is held at the output
	assign adv       = !(clip_valid && clip_stall);
	assign seg_stall = !adv;
	assign cfg_ready = 1'b1;

	// Window registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_x_min_q <= lsc_pkg::WIN_X_MIN_RST;
			win_y_min_q <= lsc_pkg::WIN_Y_MIN_RST;
			win_x_max_q <= lsc_pkg::WIN_X_MAX_RST;
			win_y_max_q <= lsc_pkg::WIN_Y_MAX_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lsc_pkg::REG_WIN_X_MIN: win_x_min_q <= cfg_data;
				lsc_pkg::REG_WIN_Y_MIN: win_y_min_q <= cfg_data;
				lsc_pkg::REG_WIN_X_MAX: win_x_max_q <= cfg_data;
				lsc_pkg::REG_WIN_Y_MAX: win_y_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Edge order: left, right, lower, upper
	assign bwin[0] = win_x_min_q;
	assign bwin[1] = win_x_max_q;
	assign bwin[2] = win_y_min_q;
	assign bwin[3] = win_y_max_q;

	// Input stage: deltas and the initial interval [0, 1]
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stv[0] <= 1'b0;
		end else if (adv) begin
			stv[0] <= seg_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st[0].x0 <= seg.start_x;
			st[0].y0 <= seg.start_y;
			st[0].dx <= lsc_pkg::WIDE_WIDTH'(seg.end_x) - lsc_pkg::WIDE_WIDTH'(seg.start_x);
			st[0].dy <= lsc_pkg::WIDE_WIDTH'(seg.end_y) - lsc_pkg::WIDE_WIDTH'(seg.start_y);
			st[0].n0 <= lsc_pkg::WIDE_WIDTH'(0);
			st[0].d0 <= lsc_pkg::WIDE_WIDTH'(1);
			st[0].n1 <= lsc_pkg::WIDE_WIDTH'(1);
			st[0].d1 <= lsc_pkg::WIDE_WIDTH'(1);
			st[0].ok <= 1'b1;
		end
	end

	// Chain of boundary cells
	for (genvar i = 0; i < NB; i++) begin : g_bound
		lsc_bound_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.sel     ('{lo_side: ((i % 2) == 0), y_axis: (i >= 2)}),
			.win     (bwin[i]),
			.in_vld  (stv[i]),
			.in_st   (st[i]),
			.out_vld (stv[i+1]),
			.out_st  (st[i+1])
		);
	end

	// Product stage: numerator times delta magnitude for each coordinate
	always_comb begin
		lsc_pkg::wide_t          n;
		lsc_pkg::wide_t          d;
		lsc_pkg::wide_t          delta;
		lsc_pkg::wide_t          amag;
		lsc_pkg::coord_t         x;
		logic [2*CW-1:0]         m;
		dv_d.ok = st[NB].ok;
		for (int j = 0; j < lsc_pkg::NUM_LANES; j++) begin
			n     = (j < 2) ? st[NB].n0 : st[NB].n1;
			d     = (j < 2) ? st[NB].d0 : st[NB].d1;
			delta = ((j % 2) == 0) ? st[NB].dx : st[NB].dy;
			x     = ((j % 2) == 0) ? st[NB].x0 : st[NB].y0;
			amag  = delta[lsc_pkg::WIDE_WIDTH-1] ? -delta : delta;
			m     = {{CW{1'b0}}, n[CW-1:0]} * {{CW{1'b0}}, amag[CW-1:0]};
			dv_d.lane[j].x   = x;
			dv_d.lane[j].neg = delta[lsc_pkg::WIDE_WIDTH-1];
			dv_d.lane[j].d   = d[CW-1:0];
			dv_d.lane[j].rem = m[2*CW-1:CW];
			dv_d.lane[j].dvd = m[CW-1:0];
			dv_d.lane[j].quo = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvv[0] <= 1'b0;
		end else if (adv) begin
			dvv[0] <= stv[NB];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv[0] <= dv_d;
		end
	end

	// Chain of division cells, one quotient bit each
	for (genvar k = 0; k < CW; k++) begin : g_div
		lsc_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.in_vld  (dvv[k]),
			.in_dv   (dv[k]),
			.out_vld (dvv[k+1]),
			.out_dv  (dv[k+1])
		);
	end

	// Floor the quotient for negative deltas, then truncate the sum toward zero
	always_comb begin
		logic signed [CW+1:0] fl;
		logic signed [CW+1:0] res;
		logic                 rnz;
		lsc_pkg::coord_t      co [lsc_pkg::NUM_LANES];
		for (int j = 0; j < lsc_pkg::NUM_LANES; j++) begin
			rnz = (dv[CW].lane[j].rem != '0);
			fl  = dv[CW].lane[j].neg ? -$signed({2'b00, dv[CW].lane[j].quo}) -
			                           $signed((CW+2)'(rnz))
			                         : $signed({2'b00, dv[CW].lane[j].quo});
			res = $signed({{2{dv[CW].lane[j].x[CW-1]}}, dv[CW].lane[j].x}) + fl;
			if (res[CW+1] && rnz) res = res + (CW+2)'(1);
			co[j] = dv[CW].ok ? res[CW-1:0] : '0;
		end
		clip_d.visible      = dv[CW].ok;
		clip_d.clip_start_x = co[0];
		clip_d.clip_start_y = co[1];
		clip_d.clip_end_x   = co[2];
		clip_d.clip_end_y   = co[3];
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_valid <= 1'b0;
		end else if (adv) begin
			clip_valid <= dvv[CW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			clip <= clip_d;
		end
	end

	// A rejected segment reports all coordinates as zero
	assert property (@(posedge clk) disable iff (!arst_n)
		clip_valid && !clip.visible |-> clip.clip_start_x == '0 && clip.clip_start_y == '0 &&
			clip.clip_end_x == '0 && clip.clip_end_y == '0)
		else $error("rejected item carries nonzero coordinates");

	// A new result only appears from the last division cell
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(clip_valid) |-> $past(dvv[CW]))
		else $error("result valid without an item in the last division cell");

	// A held result keeps the last boundary cell and the last division cell frozen
	assert property (@(posedge clk) disable iff (!arst_n)
		clip_valid && clip_stall |=> $stable(dvv[CW]) && $stable(stv[NB]))
		else $error("pipeline moved while output held");

endmodule
`default_nettype wire

// ===== dv/line_segment_window_clip_tb.sv =====
// Testbench: segment clipper checked item by item against an exact-fraction predictor.
`timescale 1ns / 1ps
`default_nettype none
module line_segment_window_clip_tb;

	localparam int LATENCY_WAIT = 2 * (lsc_pkg::COORD_WIDTH + 11);

	// Window copy and queue of predicted clip results
	class clip_scoreboard;
		longint wx_min, wy_min, wx_max, wy_max;
		lsc_pkg::clip_t clip_q[$];
		int     errors;

		function void set_window(lsc_pkg::reg_idx_t idx, lsc_pkg::coord_t v);
			case (idx)
				lsc_pkg::REG_WIN_X_MIN: wx_min = v;
				lsc_pkg::REG_WIN_Y_MIN: wy_min = v;
				lsc_pkg::REG_WIN_X_MAX: wx_max = v;
				lsc_pkg::REG_WIN_Y_MAX: wy_max = v;
				default: ;
			endcase
		endfunction

		// x0 + n/d * delta, truncated toward zero
		function lsc_pkg::coord_t interp(longint x, longint n, longint d, longint delta);
			longint num;
			num = x * d + n * delta;
			return lsc_pkg::coord_t'(num / d);
		endfunction

		function void note_segment(lsc_pkg::seg_t s);
			longint x0, y0, dx, dy, n0, d0, n1, d1, tn, td;
			longint p[4], q[4];
			bit     ok;
			lsc_pkg::clip_t r;
			x0 = s.start_x;
			y0 = s.start_y;
			dx = longint'(s.end_x) - x0;
			dy = longint'(s.end_y) - y0;
			p[0] = -dx; q[0] = x0 - wx_min;
			p[1] = dx;  q[1] = wx_max - x0;
			p[2] = -dy; q[2] = y0 - wy_min;
			p[3] = dy;  q[3] = wy_max - y0;
			n0 = 0; d0 = 1; n1 = 1; d1 = 1;
			ok = 1;
			// narrow [t0, t1] boundary by boundary
			for (int i = 0; i < 4 && ok; i++) begin
				if (p[i] == 0) begin
					if (q[i] < 0) ok = 0;
				end else begin
					tn = (p[i] < 0) ? -q[i] : q[i];
					td = (p[i] < 0) ? -p[i] : p[i];
					if (p[i] < 0) begin
						if (tn * d1 > n1 * td) ok = 0;
						else if (tn * d0 > n0 * td) begin
							n0 = tn; d0 = td;
						end
					end else begin
						if (tn * d0 < n0 * td) ok = 0;
						else if (tn * d1 < n1 * td) begin
							n1 = tn; d1 = td;
						end
					end
				end
			end
			r = '0;
			if (ok) begin
				r.visible = 1'b1;
				r.clip_start_x = interp(x0, n0, d0, dx);
				r.clip_start_y = interp(y0, n0, d0, dy);
				r.clip_end_x = interp(x0, n1, d1, dx);
				r.clip_end_y = interp(y0, n1, d1, dy);
			end
			clip_q.push_back(r);
		endfunction

		function void check_clip(lsc_pkg::clip_t got);
			lsc_pkg::clip_t want;
			if (clip_q.size() == 0) begin
				$display("%0t: unexpected result %p", $time, got);
				errors++;
				return;
			end
			want = clip_q.pop_front();
			if (got.visible !== want.visible) begin
				$display("%0t: visible exp %0d got %0d", $time, want.visible, got.visible);
				errors++;
			end
			if (got.clip_start_x !== want.clip_start_x) begin
				$display("%0t: clip_start_x exp %0d got %0d", $time,
					want.clip_start_x, got.clip_start_x);
				errors++;
			end
			if (got.clip_start_y !== want.clip_start_y) begin
				$display("%0t: clip_start_y exp %0d got %0d", $time,
					want.clip_start_y, got.clip_start_y);
				errors++;
			end
			if (got.clip_end_x !== want.clip_end_x) begin
				$display("%0t: clip_end_x exp %0d got %0d", $time,
					want.clip_end_x, got.clip_end_x);
				errors++;
			end
			if (got.clip_end_y !== want.clip_end_y) begin
				$display("%0t: clip_end_y exp %0d got %0d", $time,
					want.clip_end_y, got.clip_end_y);
				errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              seg_valid;
	logic              seg_stall;
	lsc_pkg::seg_t     seg;
	logic              clip_valid;
	logic              clip_stall;
	lsc_pkg::clip_t    clip;
	logic              cfg_valid;
	logic              cfg_ready;
	lsc_pkg::reg_idx_t cfg_index;
	lsc_pkg::coord_t   cfg_data;

	clip_scoreboard sb;
	int unsigned    cyc;

	line_segment_window_clip dut (
		.clk(clk),
		.arst_n(arst_n),
		.seg_valid(seg_valid),
		.seg_stall(seg_stall),
		.seg(seg),
		.clip_valid(clip_valid),
		.clip_stall(clip_stall),
		.clip(clip),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Note accepted items, check accepted results
	always @(posedge clk) begin
		if (arst_n && seg_valid && !seg_stall) sb.note_segment(seg);
		if (arst_n && clip_valid && !clip_stall) sb.check_clip(clip);
	end

	// Stall the result side: quiet, light and heavy phases plus one long hold
	initial begin
		cyc = 0;
		clip_stall = 1'b0;
		forever begin
			@(posedge clk);
			cyc <= cyc + 1;
			if (cyc >= 150 && cyc < 450) clip_stall <= 1'b1;
			else case ((cyc / 500) % 3)
				0: clip_stall <= 1'b0;
				1: clip_stall <= ($urandom_range(9) < 3);
				default: clip_stall <= ($urandom_range(9) < 7);
			endcase
		end
	end

	// Offer one item; hold it until accepted, with an occasional gap before it
	task automatic send_segment(input lsc_pkg::seg_t s);
		int gap;
		if ($urandom_range(5) == 0) begin
			gap = $urandom_range(8, 1);
			seg_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		seg_valid <= 1'b1;
		seg <= s;
		do @(posedge clk); while (seg_stall);
	endtask

	task automatic send_xy(input int sx, input int sy, input int ex, input int ey);
		lsc_pkg::seg_t s;
		s.start_x = lsc_pkg::coord_t'(sx);
		s.start_y = lsc_pkg::coord_t'(sy);
		s.end_x = lsc_pkg::coord_t'(ex);
		s.end_y = lsc_pkg::coord_t'(ey);
		send_segment(s);
	endtask

	task automatic drain();
		seg_valid <= 1'b0;
		while (sb.clip_q.size() != 0) @(posedge clk);
		repeat (LATENCY_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(input lsc_pkg::reg_idx_t idx, input int v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= lsc_pkg::coord_t'(v);
		do @(posedge clk); while (!cfg_ready);
		sb.set_window(idx, lsc_pkg::coord_t'(v));
		cfg_valid <= 1'b0;
	endtask

	task automatic set_window(input int x0, input int y0, input int x1, input int y1);
		write_reg(lsc_pkg::REG_WIN_X_MIN, x0);
		write_reg(lsc_pkg::REG_WIN_Y_MIN, y0);
		write_reg(lsc_pkg::REG_WIN_X_MAX, x1);
		write_reg(lsc_pkg::REG_WIN_Y_MAX, y1);
	endtask

	// Coordinate near an edge span, clamped to the field range
	function automatic int near_span(longint lo, longint hi);
		longint a, b, v;
		a = (lo < hi ? lo : hi) - 60;
		b = (lo < hi ? hi : lo) + 60;
		v = a + longint'($urandom_range(32'(b - a)));
		if (v < -32768) v = -32768;
		if (v > 32767) v = 32767;
		return int'(v);
	endfunction

	task automatic random_segments(input int count);
		int sx, sy, ex, ey;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(5))
				0: begin
					sx = int'(lsc_pkg::coord_t'($urandom));
					sy = int'(lsc_pkg::coord_t'($urandom));
					ex = int'(lsc_pkg::coord_t'($urandom));
					ey = int'(lsc_pkg::coord_t'($urandom));
				end
				1: begin
					sx = near_span(sb.wx_min, sb.wx_max); sy = near_span(sb.wy_min, sb.wy_max);
					ex = sx; ey = sy;
				end
				2: begin
					sx = near_span(sb.wx_min, sb.wx_max); sy = near_span(sb.wy_min, sb.wy_max);
					ex = $urandom_range(1) ? sx : near_span(sb.wx_min, sb.wx_max);
					ey = (ex != sx) ? sy : near_span(sb.wy_min, sb.wy_max);
				end
				default: begin
					sx = near_span(sb.wx_min, sb.wx_max); sy = near_span(sb.wy_min, sb.wy_max);
					ex = near_span(sb.wx_min, sb.wx_max); ey = near_span(sb.wy_min, sb.wy_max);
				end
			endcase
			send_xy(sx, sy, ex, ey);
		end
	endtask

	initial begin
		sb = new();
		sb.wx_min = lsc_pkg::WIN_X_MIN_RST;
		sb.wy_min = lsc_pkg::WIN_Y_MIN_RST;
		sb.wx_max = lsc_pkg::WIN_X_MAX_RST;
		sb.wy_max = lsc_pkg::WIN_Y_MAX_RST;
		arst_n = 1'b0;
		seg_valid = 1'b0;
		seg = '0;
		cfg_valid = 1'b0;
		cfg_index = lsc_pkg::REG_WIN_X_MIN;
		cfg_data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items against the reset window
		send_xy(100, 100, 200, 200);
		send_xy(-100, 240, 800, 240);
		send_xy(320, -50, 320, 600);
		send_xy(-100, -100, -10, -50);
		send_xy(50, 50, 50, 50);
		send_xy(700, 50, 700, 50);
		send_xy(0, 0, 0, 0);
		send_xy(639, 479, 639, 479);
		send_xy(-10, 0, 0, 10);
		send_xy(-10, 0, 0, -10);
		send_xy(-32768, -32768, 32767, 32767);
		send_xy(32767, -32768, -32768, 32767);
		send_xy(32767, 32767, -32768, -32768);
		send_xy(-32768, 200, 32767, 201);
		send_xy(600, -5, 700, 500);
		send_xy(639, 0, 639, 479);
		send_xy(640, 0, 640, 479);
		send_xy(-1, 3, 3, -1);
		send_xy(5, 480, 600, 480);
		send_xy(300, 200, 1000, 201);
		drain();

		random_segments(100);
		drain();
		set_window(-32768, -32768, 32767, 32767);
		send_xy(-32768, -32768, 32767, 32767);
		send_xy(32767, 0, -32768, 0);
		random_segments(80);
		drain();
		set_window(100, 100, -100, -100);
		send_xy(0, 0, 0, 0);
		send_xy(-200, -200, 200, 200);
		random_segments(40);
		drain();
		set_window(-5, -3, 5, 3);
		random_segments(80);
		drain();
		set_window(32767, -32768, 32767, -32768);
		send_xy(32767, -32768, 32767, -32768);
		send_xy(32767, 0, 32767, -32768);
		random_segments(20);
		drain();
		set_window(int'(lsc_pkg::coord_t'($urandom)), int'(lsc_pkg::coord_t'($urandom)),
			int'(lsc_pkg::coord_t'($urandom)), int'(lsc_pkg::coord_t'($urandom)));
		random_segments(40);
		drain();
		set_window(-300, -200, 300, 250);
		random_segments(60);
		drain();

		if (sb.errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// Bound the run
	initial begin
		#(12 * 400000);
		$display("Regression FAIL");
		$finish;
	end

endmodule
`default_nettype wire
